// ===== rtl/core/rlp_pkg.sv =====
package rlp_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;

    // header byte boundaries
    localparam logic [7:0] HDR_SHORT_STR = 8'h80;
    localparam logic [7:0] HDR_LONG_STR  = 8'hb8;
    localparam logic [7:0] HDR_SHORT_LST = 8'hc0;
    localparam logic [7:0] HDR_LONG_LST  = 8'hf8;

    // configuration register indexes
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    // mode register values
    localparam logic MODE_FIND  = 1'b0;
    localparam logic MODE_COUNT = 1'b1;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_ABSENT    = 3'd1;
    localparam logic [2:0] ST_COUNTED   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TOO_WIDE  = 3'd4;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_STR  = 2'd1;
    localparam logic [1:0] KIND_LIST = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  item_kind;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic [31:0] item_count;
    } out_item_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] target_index;
    } cfg_t;

endpackage

// ===== rtl/core/rlp_in_reg.sv =====
module rlp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rlp_pkg::in_item_t in_item,
    input  logic              take,
    output logic              held_valid,
    output rlp_pkg::in_item_t held_item
);
    import rlp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // a new byte may enter in the same cycle the held one is taken
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/core/rlp_parser.sv =====
module rlp_parser #(
    parameter int LENGTH_BITS = rlp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rlp_pkg::cfg_t      cfg,
    input  logic               item_valid,
    input  rlp_pkg::in_item_t  item,
    output logic               take,
    output logic               out_valid,
    input  logic               out_stall,
    output rlp_pkg::out_item_t out_data
);
    import rlp_pkg::*;

    localparam int MaxLenBytes = LENGTH_BITS / 8;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_SKIP
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            pos_reg, pos_next;
    logic [31:0]            items_reg, items_next;
    logic [3:0]             left_reg, left_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] skip_reg, skip_next;
    logic                   found_reg, found_next;
    logic                   error_reg, error_next;
    logic [1:0]             fkind_reg, fkind_next;
    logic [31:0]            foff_reg, foff_next;
    logic [31:0]            flen_reg, flen_next;
    logic [1:0]             pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    logic                   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign take      = item_valid && (!item.last_byte || out_free);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic                     done;
        logic                     done_single;
        logic [31:0]              done_idx;
        logic [1:0]               done_kind;
        logic [31:0]              done_off;
        logic [LENGTH_BITS-1:0]   done_len;
        logic [LENGTH_BITS+31:0]  len_ext;
        logic [3:0]               nlen;
        logic [7:0]               c;
        logic                     incomplete;
        logic [2:0]               status;

        c           = item.data_byte;
        done        = 1'b0;
        done_single = 1'b0;
        done_idx    = items_reg;
        done_kind   = KIND_BYTE;
        done_off    = pos_reg + 32'd1;
        done_len    = '0;
        len_ext     = '0;
        nlen        = 4'd0;
        incomplete  = 1'b0;
        status      = ST_ABSENT;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        items_next     = items_reg;
        left_next      = left_reg;
        acc_next       = acc_reg;
        skip_next      = skip_reg;
        found_next     = found_reg;
        error_next     = error_reg;
        fkind_next     = fkind_reg;
        foff_next      = foff_reg;
        flen_next      = flen_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (take)
        begin
            if (!error_reg)
            begin
                case (phase_reg)
                    PH_LENGTH:
                    begin
                        acc_next  = LENGTH_BITS'({acc_reg, c});
                        left_next = left_reg - 4'd1;
                        if (left_reg == 4'd1)
                        begin
                            done      = 1'b1;
                            done_idx  = items_reg - 32'd1;
                            done_kind = pend_reg;
                            done_len  = acc_next;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - LENGTH_BITS'(1);
                        if (skip_reg == LENGTH_BITS'(1))
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        items_next = items_reg + 32'd1;
                        if (c < HDR_SHORT_STR)
                        begin
                            done        = 1'b1;
                            done_single = 1'b1;
                            done_kind   = KIND_BYTE;
                            done_off    = pos_reg;
                            done_len    = LENGTH_BITS'(1);
                        end
                        else if (c < HDR_LONG_STR)
                        begin
                            done      = 1'b1;
                            done_kind = KIND_STR;
                            done_len  = LENGTH_BITS'(c - HDR_SHORT_STR);
                        end
                        else if (c >= HDR_SHORT_LST && c < HDR_LONG_LST)
                        begin
                            done      = 1'b1;
                            done_kind = KIND_LIST;
                            done_len  = LENGTH_BITS'(c - HDR_SHORT_LST);
                        end
                        else
                        begin
                            // long forms carry 1 to 8 length bytes in the low bits
                            nlen = {1'b0, c[2:0]} + 4'd1;
                            if (32'(nlen) > MaxLenBytes)
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                pend_next  = (c < HDR_SHORT_LST) ? KIND_STR : KIND_LIST;
                                left_next  = nlen;
                                acc_next   = '0;
                                phase_next = PH_LENGTH;
                            end
                        end
                    end
                endcase

                if (done)
                begin
                    len_ext = {32'd0, done_len};
                    if (cfg.mode == MODE_FIND && !found_reg && done_idx == cfg.target_index)
                    begin
                        found_next = 1'b1;
                        fkind_next = done_kind;
                        foff_next  = done_off;
                        flen_next  = len_ext[31:0];
                    end
                    if (done_len != '0 && !done_single)
                    begin
                        skip_next  = done_len;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            pos_next = pos_reg + 32'd1;

            if (item.last_byte)
            begin
                incomplete = (phase_next != PH_HEADER);
                if (cfg.mode == MODE_FIND)
                begin
                    if (found_next)
                        status = ST_FOUND;
                    else if (error_next)
                        status = ST_TOO_WIDE;
                    else if (incomplete)
                        status = ST_TRUNCATED;
                    else
                        status = ST_ABSENT;
                end
                else
                begin
                    if (error_next)
                        status = ST_TOO_WIDE;
                    else if (incomplete)
                        status = ST_TRUNCATED;
                    else
                        status = ST_COUNTED;
                end
                out_next.status     = status;
                out_next.item_count = items_next;
                if (cfg.mode == MODE_FIND && found_next)
                begin
                    out_next.item_kind      = fkind_next;
                    out_next.payload_offset = foff_next;
                    out_next.payload_length = flen_next;
                end
                else
                begin
                    out_next.item_kind      = KIND_BYTE;
                    out_next.payload_offset = 32'd0;
                    out_next.payload_length = 32'd0;
                end
                out_valid_next = 1'b1;

                // stream ends: back to the reset state
                phase_next = PH_HEADER;
                pos_next   = 32'd0;
                items_next = 32'd0;
                left_next  = 4'd0;
                acc_next   = '0;
                skip_next  = '0;
                found_next = 1'b0;
                error_next = 1'b0;
                fkind_next = KIND_BYTE;
                foff_next  = 32'd0;
                flen_next  = 32'd0;
                pend_next  = KIND_BYTE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 32'd0;
            items_reg     <= 32'd0;
            left_reg      <= 4'd0;
            acc_reg       <= '0;
            skip_reg      <= '0;
            found_reg     <= 1'b0;
            error_reg     <= 1'b0;
            fkind_reg     <= KIND_BYTE;
            foff_reg      <= 32'd0;
            flen_reg      <= 32'd0;
            pend_reg      <= KIND_BYTE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            items_reg     <= items_next;
            left_reg      <= left_next;
            acc_reg       <= acc_next;
            skip_reg      <= skip_next;
            found_reg     <= found_next;
            error_reg     <= error_next;
            fkind_reg     <= fkind_next;
            foff_reg      <= foff_next;
            flen_reg      <= flen_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

// ===== rtl/core/rlp_top_level_item_locator.sv =====
// the result is registered, valid in the cycle after the last byte is taken
// throughput: one byte per cycle, set by the byte register and parse-state update,
// save when a result waits in the output register: it holds up only bytes marked last
// reset: asynchronous, clears parse state, output valid and mode/target registers
module rlp_top_level_item_locator #(
    parameter int LENGTH_BITS = rlp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  rlp_pkg::in_item_t  byte_data,
    output logic               result_valid,
    input  logic               result_stall,
    output rlp_pkg::out_item_t result_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import rlp_pkg::*;

    cfg_t     cfg_reg;
    logic     held_valid;
    in_item_t held_item;
    logic     take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   cfg_reg.mode         <= cfg_wdata[0];
                CFG_TARGET: cfg_reg.target_index <= cfg_wdata;
                default:    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    rlp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_valid),
        .in_stall   (byte_stall),
        .in_item    (byte_data),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rlp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (held_valid),
        .item       (held_item),
        .take       (take),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .out_data   (result_data)
    );

endmodule
